### rtl/core/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define IIRDF1_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication, ignored while reset is active.
`define IIRDF1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

### rtl/core/iirdf1_pkg.sv
// Types and constants of the direct form I IIR filter.
`default_nettype none

package iirdf1_pkg;

    localparam int SMP_W      = 32;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SMP_W + COEF_W;
    // Up to seven products of at most 2^46 each.
    localparam int ACC_W      = 50;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int ORDER_W    = 2;
    localparam int KIND_W     = 2;

    localparam logic [KIND_W-1:0] KIND_FILTER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SHIFT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER       = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [SMP_W-1:0] sample;
    } sample_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic                    divide_error;
    } result_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/core/iirdf1_divider.sv
// Radix-2 restoring divider for the accumulator magnitude by the a0 magnitude.
`default_nettype none

module iirdf1_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  iirdf1_pkg::div_ctrl_t               ctrl,
    input  logic [iirdf1_pkg::ACC_W-1:0]        dividend,
    input  logic [iirdf1_pkg::COEF_W-1:0]       divisor,
    output iirdf1_pkg::div_stat_t               stat,
    output logic [iirdf1_pkg::ACC_W-1:0]        quotient
);
    import iirdf1_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]  work_reg;
    logic [COEF_W-1:0] rem_reg;
    logic [COEF_W-1:0] dsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [COEF_W:0]   rem_shift;
    logic [COEF_W:0]   rem_diff;
    logic              fits;

    assign rem_shift = {rem_reg, work_reg[ACC_W-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ACC_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient bits shift in where dividend bits shift out.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[ACC_W-2:0], fits};
            rem_reg  <= fits ? rem_diff[COEF_W-1:0] : rem_shift[COEF_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg;

endmodule

`default_nettype wire

### rtl/core/iir_direct_form_one_filter.sv
// Top level of the direct form I IIR filter with a shared multiply-accumulate unit.
//
//   channel    direction  handshake                 payload
//   sample     in         sample_valid/sample_stall iirdf1_pkg::sample_t (kind, sample)
//   result     out        result_valid/result_stall iirdf1_pkg::result_t (filtered, divide_error)
//   cfg        in         cfg_write                 cfg_index, cfg_data
//
// A filter transaction runs from acceptance to result through 2*order+1 multiply steps,
// the accumulator drain and a0 test, the 50-step divider and the result load (with a0 at
// zero, the division is skipped). A set or unknown transaction goes straight to the result
// load; a shift first sweeps all 2*(MAX_ORDER+1) history entries. sample_stall is high from
// acceptance until the result is loaded; a loaded result holds under result_stall while the
// next transaction runs. Reset clears both histories and restores the register defaults.
`default_nettype none

`include "assert_macros.svh"

module iir_direct_form_one_filter #(
    parameter int MAX_ORDER = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  iirdf1_pkg::sample_t                  sample_data,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output iirdf1_pkg::result_t                  result_data,
    input  logic                                 cfg_write,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iirdf1_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import iirdf1_pkg::*;

    // History depth: entries 0..MAX_ORDER in each history.
    localparam int HD         = MAX_ORDER + 1;
    localparam int HI_W       = $clog2(HD);
    localparam int STEP_W     = $clog2(2 * HD);
    localparam int SWEEP_LAST = 2 * HD - 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [ACC_W-1:0] POS_LIM = ACC_W'(32'h7fff_ffff);
    localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(32'h8000_0000);

    // Pick one signed Q2.13 coefficient out of a packed group of four.
    function automatic logic signed [COEF_W-1:0] coeff_at(
        input logic [CFG_DATA_W-1:0] coeffs,
        input logic [1:0]            idx
    );
        logic signed [COEF_W-1:0] c;
        case (idx)
            2'd0:    c = coeffs[15:0];
            2'd1:    c = coeffs[31:16];
            2'd2:    c = coeffs[47:32];
            default: c = coeffs[63:48];
        endcase
        return c;
    endfunction

    // Add and clamp to the signed 32-bit range.
    function automatic logic signed [SMP_W-1:0] sat_add(
        input logic signed [SMP_W-1:0] a,
        input logic signed [SMP_W-1:0] b
    );
        logic signed [SMP_W:0] s;
        logic signed [SMP_W-1:0] r;
        s = {a[SMP_W-1], a} + {b[SMP_W-1], b};
        if (s[SMP_W] != s[SMP_W-1])
            r = s[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
        else
            r = s[SMP_W-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic [CFG_DATA_W-1:0]  ff_coeffs_reg;
    logic [CFG_DATA_W-1:0]  fb_coeffs_reg;
    logic [ORDER_W-1:0]     filter_order_reg;

    // Sequencer and datapath state.
    logic [2:0]               state_reg,     state_next;
    logic [STEP_W-1:0]        step_reg,      step_next;
    logic [STEP_W-1:0]        order_reg,     order_next;
    logic signed [SMP_W-1:0]  in_hist_reg  [HD];
    logic signed [SMP_W-1:0]  in_hist_next [HD];
    logic signed [SMP_W-1:0]  out_hist_reg [HD];
    logic signed [SMP_W-1:0]  out_hist_next[HD];
    logic signed [PROD_W-1:0] prod_reg,      prod_next;
    logic                     prod_sub_reg,  prod_sub_next;
    logic                     prod_vld_reg,  prod_vld_next;
    logic signed [ACC_W-1:0]  acc_reg,       acc_next;
    logic                     q_neg_reg,     q_neg_next;
    logic                     err_reg,       err_next;
    logic signed [SMP_W-1:0]  shift_val_reg, shift_val_next;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_data_reg,  result_data_next;

    // Datapath wires.
    logic                     accept;
    logic                     out_free;
    logic [STEP_W-1:0]        ord_eff;
    logic [STEP_W-1:0]        last_term;
    logic                     issuing;
    logic                     is_fb;
    logic [STEP_W-1:0]        fb_j;
    logic [STEP_W-1:0]        fb_prev;
    logic [1:0]               coef_idx;
    logic signed [COEF_W-1:0] coef;
    logic                     sw_is_out;
    logic [STEP_W-1:0]        sw_off;
    logic                     rd_is_out;
    logic [HI_W-1:0]          rd_idx;
    logic signed [SMP_W-1:0]  rd_hist;
    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SMP_W-1:0]  sweep_sum;
    logic signed [COEF_W-1:0] a0;
    logic [COEF_W-1:0]        a0_mag;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W-1:0]         quo;
    logic signed [SMP_W-1:0]  y_sat;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;

    assign accept   = sample_valid && !sample_stall;
    assign out_free = !result_valid_reg || !result_stall;

    // Orders above MAX_ORDER run as MAX_ORDER.
    assign ord_eff   = (filter_order_reg > ORDER_W'(MAX_ORDER)) ? STEP_W'(MAX_ORDER)
                                                                : STEP_W'(filter_order_reg);
    assign last_term = STEP_W'({order_reg, 1'b0});
    assign issuing   = step_reg <= last_term;

    // Tap decode: steps 0..order weight the input history by b, the rest subtract
    // the output history weighted by a1..a_order.
    assign is_fb    = step_reg > order_reg;
    assign fb_j     = step_reg - order_reg;
    assign fb_prev  = fb_j - STEP_W'(1);
    assign coef_idx = is_fb ? fb_j[1:0] : step_reg[1:0];
    assign coef     = coeff_at(is_fb ? fb_coeffs_reg : ff_coeffs_reg, coef_idx);

    // Sweep decode: input entries first, then output entries.
    assign sw_is_out = step_reg >= STEP_W'(HD);
    assign sw_off    = step_reg - STEP_W'(HD);

    // One history read port shared by the tap walk and the sweep.
    always_comb
    begin
        if (state_reg == ST_SWEEP)
        begin
            rd_is_out = sw_is_out;
            rd_idx    = sw_is_out ? sw_off[HI_W-1:0] : step_reg[HI_W-1:0];
        end
        else
        begin
            rd_is_out = is_fb;
            rd_idx    = is_fb ? fb_prev[HI_W-1:0] : step_reg[HI_W-1:0];
        end
    end

    assign rd_hist   = rd_is_out ? out_hist_reg[rd_idx] : in_hist_reg[rd_idx];
    assign product   = coef * rd_hist;
    assign acc_sum   = prod_sub_reg ? acc_reg - ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
    assign sweep_sum = sat_add(rd_hist, shift_val_reg);

    assign a0      = fb_coeffs_reg[COEF_W-1:0];
    assign a0_mag  = a0[COEF_W-1] ? COEF_W'(-a0) : COEF_W'(a0);
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

    // Apply the quotient sign and clamp to 32 bits.
    always_comb
    begin
        if (q_neg_reg)
            y_sat = (quo > NEG_LIM) ? {1'b1, {(SMP_W-1){1'b0}}} : -quo[SMP_W-1:0];
        else
            y_sat = (quo > POS_LIM) ? {1'b0, {(SMP_W-1){1'b1}}} : quo[SMP_W-1:0];
    end

    iirdf1_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (acc_mag),
        .divisor  (a0_mag),
        .stat     (div_stat),
        .quotient (quo)
    );

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        order_next        = order_reg;
        in_hist_next      = in_hist_reg;
        out_hist_next     = out_hist_reg;
        prod_next         = prod_reg;
        prod_sub_next     = prod_sub_reg;
        prod_vld_next     = 1'b0;
        acc_next          = acc_reg;
        q_neg_next        = q_neg_reg;
        err_next          = err_reg;
        shift_val_next    = shift_val_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_data_next  = result_data_reg;
        div_ctrl.start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    err_next = 1'b0;
                    case (sample_data.kind)
                        KIND_FILTER:
                        begin
                            // Advance the input history and start the tap walk.
                            for (int i = HD - 1; i > 0; i--)
                                in_hist_next[i] = in_hist_reg[i-1];
                            in_hist_next[0] = sample_data.sample;
                            order_next      = ord_eff;
                            step_next       = '0;
                            acc_next        = '0;
                            state_next      = ST_MAC;
                        end
                        KIND_SET:
                        begin
                            for (int i = 0; i < HD; i++)
                            begin
                                in_hist_next[i]  = sample_data.sample;
                                out_hist_next[i] = sample_data.sample;
                            end
                            state_next = ST_OUT;
                        end
                        KIND_SHIFT:
                        begin
                            shift_val_next = sample_data.sample;
                            step_next      = '0;
                            state_next     = ST_SWEEP;
                        end
                        default:
                        begin
                            // Unknown kind: leave the state alone, report the newest output.
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_MAC:
            begin
                // Register the product, then accumulate it in the next cycle.
                if (prod_vld_reg)
                    acc_next = acc_sum;
                if (issuing)
                begin
                    prod_next     = product;
                    prod_sub_next = is_fb;
                    prod_vld_next = 1'b1;
                    step_next     = step_reg + STEP_W'(1);
                end
                else if (!prod_vld_reg)
                begin
                    if (a0 == '0)
                    begin
                        // Zero a0: push zero and flag the transaction.
                        for (int i = HD - 1; i > 0; i--)
                            out_hist_next[i] = out_hist_reg[i-1];
                        out_hist_next[0] = '0;
                        err_next         = 1'b1;
                        state_next       = ST_OUT;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        q_neg_next     = acc_reg[ACC_W-1] ^ a0[COEF_W-1];
                        state_next     = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    for (int i = HD - 1; i > 0; i--)
                        out_hist_next[i] = out_hist_reg[i-1];
                    out_hist_next[0] = y_sat;
                    state_next       = ST_OUT;
                end
            end

            ST_SWEEP:
            begin
                if (sw_is_out)
                    out_hist_next[rd_idx] = sweep_sum;
                else
                    in_hist_next[rd_idx] = sweep_sum;
                if (step_reg == STEP_W'(SWEEP_LAST))
                    state_next = ST_OUT;
                else
                    step_next = step_reg + STEP_W'(1);
            end

            ST_OUT:
            begin
                // Hold until the result register is free.
                if (out_free)
                begin
                    result_valid_next             = 1'b1;
                    result_data_next.filtered     = out_hist_reg[0];
                    result_data_next.divide_error = err_reg;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            order_reg        <= '0;
            prod_vld_reg     <= 1'b0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            ff_coeffs_reg    <= '0;
            fb_coeffs_reg    <= CFG_DATA_W'(8192);
            filter_order_reg <= '0;
            for (int i = 0; i < HD; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            order_reg        <= order_next;
            prod_vld_reg     <= prod_vld_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
            in_hist_reg      <= in_hist_next;
            out_hist_reg     <= out_hist_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FEEDFORWARD: ff_coeffs_reg    <= cfg_data;
                    REG_FEEDBACK:    fb_coeffs_reg    <= cfg_data;
                    REG_ORDER:       filter_order_reg <= cfg_data[ORDER_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg        <= prod_next;
        prod_sub_reg    <= prod_sub_next;
        acc_reg         <= acc_next;
        q_neg_reg       <= q_neg_next;
        shift_val_reg   <= shift_val_next;
        result_data_reg <= result_data_next;
    end

    assign sample_stall = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    `IIRDF1_ASSERT_NEXT(a_filter_enters_mac, clk, rst_n,
        accept && sample_data.kind == KIND_FILTER, state_reg == ST_MAC)
    `IIRDF1_ASSERT_IMPL(a_divider_busy_in_div, clk, rst_n,
        div_stat.busy || div_stat.done, state_reg == ST_DIV)
    `IIRDF1_ASSERT_NEXT(a_result_loaded, clk, rst_n,
        state_reg == ST_OUT && out_free, result_valid && state_reg == ST_IDLE)

endmodule

`default_nettype wire
